FILE: rtl/assert_macros.svh
// Assertion macros shared by the walker RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/svbw_pkg.sv
// Package for the strided vector base walker: field widths, register codes,
// cell control type, state type and the extent clamp. No dependencies.
package svbw_pkg;

	localparam int EXT_W    = 11;
	localparam int CNT_W    = 10;
	localparam int STRIDE_W = 48;
	localparam int BASE_W   = 49;
	localparam int START_W  = 47;
	localparam int BS_W     = 8;
	localparam int NDIM_W   = 3;
	localparam int AXIS_W   = 2;
	localparam int IDX_W    = 3;
	localparam int NSLOT    = 4;
	localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1024);

	typedef enum logic [IDX_W-1:0] {
		REG_DIM0  = 3'd0,
		REG_DIM1  = 3'd1,
		REG_DIM2  = 3'd2,
		REG_DIM3  = 3'd3,
		REG_NDIMS = 3'd4,
		REG_AXIS  = 3'd5,
		REG_BSTR  = 3'd6,
		REG_START = 3'd7
	} svbw_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESTART,
		ST_ADVANCE,
		ST_EMIT
	} svbw_state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic adv;
	} svbw_cell_ctl_t;

	function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] sz);
		logic [EXT_W-1:0] e;
		e = sz;
		if (sz == '0)
			e = EXT_W'(1);
		else if (sz > EXT_MAX)
			e = EXT_MAX;
		return e;
	endfunction

endpackage

FILE: rtl/strided_vector_base_walker.sv
// Strided vector base walker: a chain of MAX_DIMS digit cells plus a tail cell.
// Restart: the stride product passes one cell a cycle.
// Advance: the carry visits one cell a cycle. A finished walk goes straight to its result.
// One item at a time; the next item is taken in the cycle after the result is registered.
// Reset is asynchronous: strides, counts and base clear, walk marked finished, config to defaults.
`include "assert_macros.svh"

module strided_vector_base_walker #(
	parameter int MAX_DIMS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [svbw_pkg::BASE_W-1:0]     base_offset,
	output logic [svbw_pkg::STRIDE_W-1:0]   axis_stride,
	output logic [svbw_pkg::EXT_W-1:0]      axis_length,
	output logic                            done_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [svbw_pkg::IDX_W-1:0]      cfg_index,
	input  logic [svbw_pkg::START_W-1:0]    cfg_data
);
	import svbw_pkg::*;

	localparam int NCELL = MAX_DIMS + 1;
	localparam int CW    = $clog2(MAX_DIMS + 1);

	svbw_state_t         state_q, state_nx;
	logic [EXT_W-1:0]    dim_size_q [NSLOT];
	logic [NDIM_W-1:0]   num_dims_q;
	logic [AXIS_W-1:0]   axis_q;
	logic [BS_W-1:0]     bstride_q;
	logic [START_W-1:0]  start_q;
	logic [CW-1:0]       rcnt_q;
	logic [CW-1:0]       cursor_q;
	logic [BASE_W-1:0]   base_q;
	logic                finished_q;

	logic [NDIM_W-1:0]   ndims_eff;
	logic [BS_W-1:0]     bs_eff;
	logic                accept;
	logic                out_free;
	logic                cur_over;
	logic                cur_axis;
	logic                stepped;
	logic [BASE_W-1:0]   delta_sum;
	logic [STRIDE_W-1:0] ax_stride;
	logic [EXT_W-1:0]    ax_len;
	logic [NCELL-1:0]    adv_vec;
	logic [NCELL-1:0]    wrap_vec;

	svbw_cell_ctl_t      ctl    [NCELL];
	logic [EXT_W-1:0]    ext    [NCELL];
	logic [STRIDE_W-1:0] sin    [NCELL];
	logic [STRIDE_W-1:0] stride [NCELL];
	logic [STRIDE_W-1:0] nxt    [NCELL];
	logic [BASE_W-1:0]   delta  [NCELL];

	always_comb begin
		if (num_dims_q == '0)
			ndims_eff = NDIM_W'(1);
		else if (num_dims_q > NDIM_W'(MAX_DIMS))
			ndims_eff = NDIM_W'(MAX_DIMS);
		else
			ndims_eff = num_dims_q;
		bs_eff   = (bstride_q == '0) ? BS_W'(1) : bstride_q;
		cur_over = 32'(cursor_q) >= 32'(ndims_eff);
		cur_axis = 32'(cursor_q) == 32'(axis_q);
		ax_len   = (NDIM_W'(axis_q) < ndims_eff) ? clamp_ext(dim_size_q[axis_q]) : EXT_W'(1);
	end

	// chain of cells; the last one only holds the stride past the top dimension
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k < MAX_DIMS) begin : g_ext
			assign ext[k] = (NDIM_W'(k) < ndims_eff) ? clamp_ext(dim_size_q[k]) : EXT_W'(1);
		end else begin : g_tail
			assign ext[k] = EXT_W'(1);
		end
		if (k == 0) begin : g_head
			assign sin[k] = STRIDE_W'(bs_eff);
		end else begin : g_link
			assign sin[k] = nxt[k-1];
		end
		assign adv_vec[k] = (state_q == ST_ADVANCE) && (k < MAX_DIMS) && !cur_over && !cur_axis
			&& (32'(cursor_q) == k);
		assign ctl[k].clear = accept && restart;
		assign ctl[k].load  = (state_q == ST_RESTART) && (32'(rcnt_q) == k);
		assign ctl[k].adv   = adv_vec[k];

		svbw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[k]),
			.ext       (ext[k]),
			.stride_in (sin[k]),
			.stride    (stride[k]),
			.nxt       (nxt[k]),
			.delta     (delta[k]),
			.wrap      (wrap_vec[k])
		);
	end

	always_comb begin
		delta_sum = '0;
		ax_stride = '0;
		for (int k = 0; k < NCELL; k++) begin
			delta_sum = delta_sum | delta[k];
			if ((k < MAX_DIMS && 32'(axis_q) == k) || (k == MAX_DIMS && 32'(axis_q) >= MAX_DIMS))
				ax_stride = ax_stride | stride[k];
		end
		stepped = |(adv_vec & ~wrap_vec);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (restart)
						state_nx = ST_RESTART;
					else if (finished_q)
						state_nx = ST_EMIT;
					else
						state_nx = ST_ADVANCE;
				end
			end
			ST_RESTART: begin
				if (rcnt_q == CW'(MAX_DIMS))
					state_nx = ST_EMIT;
			end
			ST_ADVANCE: begin
				if (cur_over || stepped)
					state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE) && !in_valid;
		accept    = in_valid && !in_stall;
		out_free  = !out_valid || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rcnt_q     <= '0;
			cursor_q   <= '0;
			base_q     <= '0;
			finished_q <= 1'b1;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				rcnt_q   <= '0;
				cursor_q <= '0;
				if (restart) begin
					base_q     <= BASE_W'(start_q);
					finished_q <= 1'b0;
				end
			end
			if (state_q == ST_RESTART)
				rcnt_q <= rcnt_q + CW'(1);
			if (state_q == ST_ADVANCE) begin
				if (cur_over) begin
					finished_q <= 1'b1;
				end else begin
					base_q   <= base_q + delta_sum;
					cursor_q <= cursor_q + CW'(1);
				end
			end
			if (state_q == ST_EMIT && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			base_offset <= finished_q ? '0 : base_q;
			axis_stride <= ax_stride;
			axis_length <= ax_len;
			done_res    <= finished_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++)
				dim_size_q[i] <= EXT_W'(1);
			num_dims_q <= NDIM_W'(1);
			axis_q     <= '0;
			bstride_q  <= BS_W'(1);
			start_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (svbw_reg_t'(cfg_index))
				REG_DIM0:  dim_size_q[0] <= cfg_data[EXT_W-1:0];
				REG_DIM1:  dim_size_q[1] <= cfg_data[EXT_W-1:0];
				REG_DIM2:  dim_size_q[2] <= cfg_data[EXT_W-1:0];
				REG_DIM3:  dim_size_q[3] <= cfg_data[EXT_W-1:0];
				REG_NDIMS: num_dims_q    <= cfg_data[NDIM_W-1:0];
				REG_AXIS:  axis_q        <= cfg_data[AXIS_W-1:0];
				REG_BSTR:  bstride_q     <= cfg_data[BS_W-1:0];
				REG_START: start_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_one_digit_steps, $onehot0(adv_vec), "more than one digit advanced")
	`ASSERT_IMPLIES(a_done_base_zero, out_valid && done_res, base_offset == '0, "done beat with base")
	`ASSERT_NEXT(a_restart_clears_done, accept && restart, !finished_q, "restart left walk finished")
	`ASSERT_IMPLIES(a_cursor_range, state_q == ST_ADVANCE, 32'(cursor_q) <= 32'(ndims_eff), "cursor past dims")

endmodule

FILE: rtl/svbw_cell.sv
// One digit cell of the walker chain: stride entry, position count and the
// offset that the digit adds to the base. Depends on svbw_pkg.
`include "assert_macros.svh"

module svbw_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  svbw_pkg::svbw_cell_ctl_t       ctl,
	input  logic [svbw_pkg::EXT_W-1:0]     ext,
	input  logic [svbw_pkg::STRIDE_W-1:0]  stride_in,
	output logic [svbw_pkg::STRIDE_W-1:0]  stride,
	output logic [svbw_pkg::STRIDE_W-1:0]  nxt,
	output logic [svbw_pkg::BASE_W-1:0]    delta,
	output logic                           wrap
);
	import svbw_pkg::*;

	logic [STRIDE_W-1:0]       stride_q;
	logic [CNT_W-1:0]          count_q;
	logic [BASE_W-1:0]         contrib_q;
	logic [STRIDE_W+EXT_W-1:0] prod;

	always_comb begin
		prod   = stride_q * ext;
		nxt    = prod[STRIDE_W-1:0];
		stride = stride_q;
		wrap   = ({1'b0, count_q} + EXT_W'(1)) >= ext;
		if (!ctl.adv)
			delta = '0;
		else if (wrap)
			delta = BASE_W'(0) - contrib_q;
		else
			delta = BASE_W'(stride_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q  <= '0;
			count_q   <= '0;
			contrib_q <= '0;
		end else begin
			if (ctl.clear) begin
				count_q   <= '0;
				contrib_q <= '0;
			end
			if (ctl.load)
				stride_q <= stride_in;
			if (ctl.adv) begin
				if (wrap) begin
					count_q   <= '0;
					contrib_q <= '0;
				end else begin
					count_q   <= count_q + CNT_W'(1);
					contrib_q <= contrib_q + BASE_W'(stride_q);
				end
			end
		end
	end

	`ASSERT_IMPLIES(a_zero_count_no_offset, count_q == '0, contrib_q == '0, "offset held at count zero")
	`ASSERT_ALWAYS(a_no_mixed_ctl, !(ctl.adv && (ctl.clear || ctl.load)), "advance during restart")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for strided_vector_base_walker: a scoreboard class predicts every
// vector base, stride, length and done flag, and plain tasks drive random beats and stalls.
// Depends on svbw_pkg and the walker RTL only.
module testbench;
	import svbw_pkg::*;

	typedef struct {
		logic [BASE_W-1:0]   base;
		logic [STRIDE_W-1:0] stride;
		logic [EXT_W-1:0]    len;
		logic                done;
	} vector_rec_t;

	class walk_scoreboard;
		logic [EXT_W-1:0]    dim_reg[NSLOT];
		logic [NDIM_W-1:0]   ndims_reg;
		logic [AXIS_W-1:0]   axis_reg;
		logic [BS_W-1:0]     bstride_reg;
		logic [START_W-1:0]  start_reg;
		logic [CNT_W-1:0]    pos_cnt[NSLOT];
		logic [STRIDE_W-1:0] strides[NSLOT];
		logic [BASE_W-1:0]   cur_base;
		logic                finished;
		vector_rec_t         expected_vectors[$];
		int                  errors;

		function new();
			for (int d = 0; d < NSLOT; d++) begin
				dim_reg[d] = 1;
				pos_cnt[d] = '0;
				strides[d] = '0;
			end
			ndims_reg = 1;
			axis_reg = 0;
			bstride_reg = 1;
			start_reg = '0;
			cur_base = '0;
			finished = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(svbw_reg_t idx, logic [START_W-1:0] val);
			case (idx)
				REG_DIM0:  dim_reg[0] = val[EXT_W-1:0];
				REG_DIM1:  dim_reg[1] = val[EXT_W-1:0];
				REG_DIM2:  dim_reg[2] = val[EXT_W-1:0];
				REG_DIM3:  dim_reg[3] = val[EXT_W-1:0];
				REG_NDIMS: ndims_reg = val[NDIM_W-1:0];
				REG_AXIS:  axis_reg = val[AXIS_W-1:0];
				REG_BSTR:  bstride_reg = val[BS_W-1:0];
				REG_START: start_reg = val;
				default: ;
			endcase
		endfunction

		function int dims_used();
			if (ndims_reg == 0)
				return 1;
			if (ndims_reg > NSLOT)
				return NSLOT;
			return int'(ndims_reg);
		endfunction

		function int extent(int d);
			int e;
			if (d >= dims_used())
				return 1;
			e = int'(dim_reg[d]);
			if (e == 0)
				e = 1;
			if (e > 1024)
				e = 1024;
			return e;
		endfunction

		function void note_request(logic rs);
			vector_rec_t v;
			logic [63:0] prod;
			logic [63:0] old;
			logic [63:0] bs;
			bit          stepped;
			int          lim;
			int          a;
			a = int'(axis_reg);
			if (rs) begin
				prod = 1;
				bs = (bstride_reg == 0) ? 64'd1 : 64'(bstride_reg);
				for (int d = 0; d < NSLOT; d++) begin
					strides[d] = STRIDE_W'(bs * prod);
					prod = prod * 64'(extent(d));
					pos_cnt[d] = '0;
				end
				cur_base = BASE_W'(start_reg);
				finished = 1'b0;
			end else if (!finished) begin
				stepped = 0;
				lim = dims_used();
				for (int d = 0; d < lim && !stepped; d++) begin
					if (d != a) begin
						old = 64'(pos_cnt[d]);
						if (old + 1 >= 64'(extent(d))) begin
							pos_cnt[d] = '0;
							cur_base = cur_base - BASE_W'(64'(strides[d]) * old);
						end else begin
							pos_cnt[d] = CNT_W'(old + 1);
							cur_base = cur_base + BASE_W'(strides[d]);
							stepped = 1;
						end
					end
				end
				if (!stepped)
					finished = 1'b1;
			end
			v.base = finished ? '0 : cur_base;
			v.stride = strides[a];
			v.len = EXT_W'(extent(a));
			v.done = finished;
			expected_vectors.push_back(v);
		endfunction

		task flag(string what, logic [63:0] got, logic [63:0] want);
			$display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_vector(logic [BASE_W-1:0] base, logic [STRIDE_W-1:0] stride,
				logic [EXT_W-1:0] len, logic done);
			vector_rec_t v;
			if (expected_vectors.size() == 0) begin
				flag("unexpected beat, base", 64'(base), 64'd0);
			end else begin
				v = expected_vectors.pop_front();
				if (base !== v.base)
					flag("base_offset", 64'(base), 64'(v.base));
				if (stride !== v.stride)
					flag("axis_stride", 64'(stride), 64'(v.stride));
				if (len !== v.len)
					flag("axis_length", 64'(len), 64'(v.len));
				if (done !== v.done)
					flag("done_res", 64'(done), 64'(v.done));
			end
		endtask

		function int pending();
			return expected_vectors.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                restart;
	logic                out_valid;
	logic                out_stall;
	logic [BASE_W-1:0]   base_offset;
	logic [STRIDE_W-1:0] axis_stride;
	logic [EXT_W-1:0]    axis_length;
	logic                done_res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [START_W-1:0]  cfg_data;

	walk_scoreboard sb;
	bit             quiet;
	int             hold_len;
	int             items_sent;

	strided_vector_base_walker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.base_offset (base_offset),
		.axis_stride (axis_stride),
		.axis_length (axis_length),
		.done_res    (done_res),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_vector(base_offset, axis_stride, axis_length, done_res);
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_stall = 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end
			n = quiet ? 0 : $urandom_range(0, 11);
			out_stall = (n > 0);
			repeat (n) @(negedge clk);
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic send_beat(input logic rs);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		restart = rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(rs);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(input svbw_reg_t idx, input logic [START_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_walk(input int d0, input int d1, input int d2, input int d3,
			input int nd, input int ax, input int bs, input logic [START_W-1:0] st);
		cfg_write(REG_DIM0, START_W'(d0));
		cfg_write(REG_DIM1, START_W'(d1));
		cfg_write(REG_DIM2, START_W'(d2));
		cfg_write(REG_DIM3, START_W'(d3));
		cfg_write(REG_NDIMS, START_W'(nd));
		cfg_write(REG_AXIS, START_W'(ax));
		cfg_write(REG_BSTR, START_W'(bs));
		cfg_write(REG_START, st);
	endtask

	function automatic int pick_extent();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 2047;
		if (r == 2)
			return $urandom_range(0, 2047);
		return $urandom_range(1, 4);
	endfunction

	function automatic logic [START_W-1:0] pick_start();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return START_W'({$urandom, $urandom});
	endfunction

	task automatic mid_walk_change();
		case ($urandom_range(0, 5))
			0: cfg_write(REG_DIM0, START_W'(pick_extent()));
			1: cfg_write(REG_DIM1, START_W'(pick_extent()));
			2: cfg_write(REG_DIM2, START_W'(pick_extent()));
			3: cfg_write(REG_DIM3, START_W'(pick_extent()));
			4: cfg_write(REG_NDIMS, START_W'($urandom_range(0, 7)));
			default: cfg_write(REG_AXIS, START_W'($urandom_range(0, 3)));
		endcase
	endtask

	initial begin
		int phase;
		int n;
		int k;
		int ext[NSLOT];
		bit mid;
		sb = new();
		quiet = 0;
		hold_len = 0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		restart = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DIM0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// advance with no restart since reset
		send_beat(1'b0);
		send_beat(1'b0);
		settle();

		// clamped extents, dimension count and stride, all-ones start
		program_walk(0, 2047, 3, 1024, 7, 3, 0, '1);
		send_beat(1'b1);
		repeat (3) send_beat(1'b0);
		settle();

		// axis beyond the dimension count, walk runs past its end
		program_walk(2, 2, 5, 5, 0, 2, 255, '0);
		send_beat(1'b1);
		repeat (3) send_beat(1'b0);
		settle();

		// extents and axis changed mid walk
		program_walk(3, 4, 2, 2, 2, 1, 255, 47'h1234_5678_9ab);
		send_beat(1'b1);
		repeat (2) send_beat(1'b0);
		settle();
		cfg_write(REG_DIM0, START_W'(1));
		repeat (2) send_beat(1'b0);
		settle();
		cfg_write(REG_NDIMS, START_W'(4));
		cfg_write(REG_AXIS, START_W'(0));
		repeat (3) send_beat(1'b0);
		settle();

		phase = 0;
		while (items_sent < 1850) begin
			quiet = ($urandom_range(0, 4) == 0);
			mid = ($urandom_range(0, 4) == 0);
			for (int d = 0; d < NSLOT; d++)
				ext[d] = pick_extent();
			n = $urandom_range(10, 80);
			if (phase == 3) begin
				// one long walk so a counter climbs to the top of a 1024 extent
				k = $urandom_range(0, 3);
				for (int d = 0; d < NSLOT; d++)
					ext[d] = (d == k) ? 1024 : 1;
				program_walk(ext[0], ext[1], ext[2], ext[3], 4, (k + 1) % NSLOT,
					$urandom_range(0, 255), pick_start());
				n = 1026;
				mid = 0;
			end else begin
				program_walk(ext[0], ext[1], ext[2], ext[3], $urandom_range(0, 7),
					$urandom_range(0, 3), $urandom_range(0, 255), pick_start());
			end
			if (phase % 15 == 1)
				hold_len = 150;
			send_beat(1'b1);
			for (int i = 1; i < n; i++) begin
				if (mid && i == n / 2) begin
					settle();
					mid_walk_change();
				end
				send_beat((phase != 3) && ($urandom_range(0, 99) < 7));
			end
			settle();
			phase++;
		end

		quiet = 0;
		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
